>>> design/gtbi_pkg.sv
// shared types and constants for the gimbal table interpolator
`default_nettype none
package gtbi_pkg;
   localparam int unsigned TipColsDefault    = 128;
   localparam int unsigned TiltRowsDefault   = 128;
   localparam int unsigned TipOffsetDefault  = 38;
   localparam int unsigned TiltOffsetDefault = 55;
   localparam logic [30:0] StepReset         = 31'd4685049;
   localparam int unsigned DivIters          = 36;

   localparam logic [1:0] DIV_TIP  = 2'd0;
   localparam logic [1:0] DIV_TILT = 2'd1;
   localparam logic [1:0] DIV_LERP = 2'd2;

   localparam logic [1:0] LERP_AB_X = 2'd0;
   localparam logic [1:0] LERP_CD_X = 2'd1;
   localparam logic [1:0] LERP_AC_Y = 2'd2;
   localparam logic [1:0] LERP_EF_Y = 2'd3;

   typedef struct packed {
      logic       write_en;
      logic       query_load;
      logic       div_start;
      logic [1:0] div_sel;
      logic       store_x;
      logic       store_y;
      logic       grid_eval;
      logic       idx_eval;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       mul_en;
      logic [1:0] lerp_op;
      logic       motor;
      logic       lerp_store;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic index_err;
      logic corners_ok;
      logic grid_x;
      logic grid_y;
      logic rsp_full;
   } status_type;
endpackage
`default_nettype wire

>>> design/gtbi_div.sv
// restoring divider, one quotient bit per cycle, floor quotient and remainder
`default_nettype none
module gtbi_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [65:0] mag,
   input  wire logic        neg,
   input  wire logic [31:0] dvs,
   output logic             done,
   output logic [36:0]      quo,
   output logic [31:0]      rmd
);
   import gtbi_pkg::*;

   localparam int CntW = $clog2(DivIters);

   logic [31:0]     rem_ff, rem_in;
   logic [35:0]     dvd_ff, dvd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            neg_ff, neg_in;
   logic [31:0]     dvs_ff, dvs_in;
   logic [32:0]     trial;
   logic [32:0]     diff;
   logic            rem_nz;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[35]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = {2'b00, mag[65:36]};
         dvd_in  = mag[35:0];
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = neg;
         dvs_in  = dvs;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[31:0];
            dvd_in = {dvd_ff[34:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            dvd_in = {dvd_ff[34:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(DivIters - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
   end

   // floor correction for negative dividends
   assign rem_nz = (rem_ff != '0);
   assign done   = done_ff;
   assign quo    = neg_ff ? (37'd0 - {1'b0, dvd_ff} - {36'd0, rem_nz}) : {1'b0, dvd_ff};
   assign rmd    = (neg_ff && rem_nz) ? (dvs_ff - rem_ff) : rem_ff;
endmodule
`default_nettype wire

>>> design/gtbi_dp.sv
// datapath: tables, grid split, index check, corner reads and interpolation
`default_nettype none
module gtbi_dp #(
   parameter int unsigned TIP_COLS    = gtbi_pkg::TipColsDefault,
   parameter int unsigned TILT_ROWS   = gtbi_pkg::TiltRowsDefault,
   parameter int unsigned TIP_OFFSET  = gtbi_pkg::TipOffsetDefault,
   parameter int unsigned TILT_OFFSET = gtbi_pkg::TiltOffsetDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire gtbi_pkg::cmd_type   cmd,
   output gtbi_pkg::status_type     st,
   input  wire logic                csr_valid,
   input  wire logic [30:0]         csr_step_angle,
   input  wire logic                req_table_select,
   input  wire logic [6:0]          req_row_index,
   input  wire logic [6:0]          req_col_index,
   input  wire logic signed [31:0]  req_entry_value,
   input  wire logic signed [31:0]  req_tip_angle,
   input  wire logic signed [31:0]  req_tilt_angle,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_motor_one_angle,
   output logic signed [31:0]       rsp_motor_two_angle,
   output logic                     rsp_result_valid,
   output logic                     rsp_index_error
);
   import gtbi_pkg::*;

   localparam int Depth = TIP_COLS * TILT_ROWS;
   localparam int AddrW = $clog2(Depth);
   localparam int ColW  = $clog2(TIP_COLS);
   localparam int RowW  = $clog2(TILT_ROWS);

   logic [30:0]        step_ff;
   logic [30:0]        s_eff;
   logic signed [31:0] tip_ff, tilt_ff;
   logic signed [33:0] qx_ff, qy_ff;
   logic [30:0]        rx_ff, ry_ff;
   logic               gx_ff, gy_ff, lox_ff, loy_ff;
   logic [ColW-1:0]    col0_ff, col1_ff;
   logic [RowW-1:0]    row0_ff, row1_ff;
   logic               err_ff;
   logic signed [31:0] mem1 [Depth];
   logic signed [31:0] mem2 [Depth];
   logic signed [31:0] rd1_ff, rd2_ff;
   logic               rdv_ff;
   logic [1:0]         rds_ff;
   logic signed [31:0] corner_ff [2][4];
   logic signed [31:0] e_ff [2];
   logic signed [31:0] f_ff [2];
   logic signed [31:0] g_ff [2];
   logic signed [63:0] prod_ff;
   logic signed [31:0] z0_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] m1_ff, m2_ff;
   logic               ok_ff, ierr_ff;

   logic [65:0]        div_mag;
   logic               div_neg;
   logic [31:0]        div_dvs;
   logic               div_done;
   logic [36:0]        div_quo;
   logic [31:0]        div_rmd;

   logic signed [32:0] ang_ext;
   logic signed [65:0] lerp_n;
   logic [40:0]        lo_x, hi_x, lo_y, hi_y;
   logic signed [35:0] cx0, cx1, ry0, ry1;
   logic [AddrW-1:0]   wr_addr, rd_addr;
   logic               wr_ok;
   logic signed [31:0] z0, z1;
   logic [30:0]        frac;
   logic signed [32:0] zdiff;
   logic signed [64:0] prod;
   logic signed [36:0] lerp_sum;
   logic               ok;
   logic signed [31:0] sel1, sel2;

   assign s_eff = (step_ff == '0) ? 31'd1 : step_ff;

   // divider operand selection
   always_comb begin
      ang_ext = (cmd.div_sel == DIV_TILT) ? 33'(tilt_ff) : 33'(tip_ff);
      lerp_n  = (66'(prod_ff) <<< 1) + $signed({35'd0, s_eff});
      div_mag = '0;
      div_neg = 1'b0;
      div_dvs = {1'b0, s_eff};
      unique case (cmd.div_sel)
         DIV_TIP, DIV_TILT: begin
            div_neg = ang_ext[32];
            div_mag = 66'(ang_ext[32] ? 33'(-ang_ext) : ang_ext);
         end
         DIV_LERP: begin
            div_neg = lerp_n[65];
            div_mag = lerp_n[65] ? 66'(-lerp_n) : 66'(lerp_n);
            div_dvs = {s_eff, 1'b0};
         end
         default: begin
            div_mag = '0;
         end
      endcase
   end

   gtbi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .mag   (div_mag),
      .neg   (div_neg),
      .dvs   (div_dvs),
      .done  (div_done),
      .quo   (div_quo),
      .rmd   (div_rmd)
   );

   // nearness tests against one thousandth of a step
   assign lo_x = 41'(rx_ff) * 41'd1000;
   assign hi_x = 41'(s_eff - rx_ff) * 41'd1000;
   assign lo_y = 41'(ry_ff) * 41'd1000;
   assign hi_y = 41'(s_eff - ry_ff) * 41'd1000;

   assign cx0 = 36'(qx_ff) + 36'(gx_ff && !lox_ff) + $signed(36'(TIP_OFFSET));
   assign cx1 = cx0 + 36'(!gx_ff);
   assign ry0 = 36'(qy_ff) + 36'(gy_ff && !loy_ff) + $signed(36'(TILT_OFFSET));
   assign ry1 = ry0 + 36'(!gy_ff);

   assign wr_ok   = (11'(req_row_index) < 11'(TILT_ROWS)) && (11'(req_col_index) < 11'(TIP_COLS));
   assign wr_addr = AddrW'(RowW'(req_row_index)) * AddrW'(TIP_COLS) + AddrW'(ColW'(req_col_index));
   assign rd_addr = AddrW'(cmd.rd_sel[1] ? row1_ff : row0_ff) * AddrW'(TIP_COLS)
                  + AddrW'(cmd.rd_sel[0] ? col1_ff : col0_ff);

   always_ff @(posedge clock) begin
      if (cmd.write_en && wr_ok && !req_table_select) begin
         mem1[wr_addr] <= req_entry_value;
      end
      if (cmd.rd_en) begin
         rd1_ff <= mem1[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && wr_ok && req_table_select) begin
         mem2[wr_addr] <= req_entry_value;
      end
      if (cmd.rd_en) begin
         rd2_ff <= mem2[rd_addr];
      end
   end

   // interpolation operands
   always_comb begin
      unique case (cmd.lerp_op)
         LERP_AB_X: begin
            z0 = corner_ff[cmd.motor][0]; z1 = corner_ff[cmd.motor][1]; frac = rx_ff;
         end
         LERP_CD_X: begin
            z0 = corner_ff[cmd.motor][2]; z1 = corner_ff[cmd.motor][3]; frac = rx_ff;
         end
         LERP_AC_Y: begin
            z0 = corner_ff[cmd.motor][0]; z1 = corner_ff[cmd.motor][2]; frac = ry_ff;
         end
         default: begin
            z0 = e_ff[cmd.motor]; z1 = f_ff[cmd.motor]; frac = ry_ff;
         end
      endcase
      zdiff    = 33'(z1) - 33'(z0);
      prod     = 65'(zdiff) * $signed({34'd0, frac});
      lerp_sum = 37'(z0_ff) + $signed(div_quo);
   end

   always_comb begin
      if (gx_ff && gy_ff) begin
         ok = 1'b1;
      end else if (gx_ff) begin
         ok = !corner_ff[0][0][31] && !corner_ff[0][2][31];
      end else if (gy_ff) begin
         ok = !corner_ff[0][0][31] && !corner_ff[0][1][31];
      end else begin
         ok = !corner_ff[0][0][31] && !corner_ff[0][1][31]
            && !corner_ff[0][2][31] && !corner_ff[0][3][31];
      end
      if (gx_ff && gy_ff) begin
         sel1 = corner_ff[0][0]; sel2 = corner_ff[1][0];
      end else if (gy_ff) begin
         sel1 = e_ff[0]; sel2 = e_ff[1];
      end else begin
         sel1 = g_ff[0]; sel2 = g_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= StepReset;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            step_ff <= csr_step_angle;
         end
         rdv_ff <= cmd.rd_en;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      rds_ff <= cmd.rd_sel;
      if (cmd.query_load) begin
         tip_ff  <= req_tip_angle;
         tilt_ff <= req_tilt_angle;
      end
      if (cmd.store_x) begin
         qx_ff <= 34'(div_quo);
         rx_ff <= 31'(div_rmd);
      end
      if (cmd.store_y) begin
         qy_ff <= 34'(div_quo);
         ry_ff <= 31'(div_rmd);
      end
      if (cmd.grid_eval) begin
         lox_ff <= lo_x < 41'(s_eff);
         loy_ff <= lo_y < 41'(s_eff);
         gx_ff  <= (lo_x < 41'(s_eff)) || (hi_x < 41'(s_eff));
         gy_ff  <= (lo_y < 41'(s_eff)) || (hi_y < 41'(s_eff));
      end
      if (cmd.idx_eval) begin
         err_ff  <= cx0[35] || ry0[35] || (cx1 >= $signed(36'(TIP_COLS)))
                 || (ry1 >= $signed(36'(TILT_ROWS)));
         col0_ff <= ColW'(cx0);
         col1_ff <= ColW'(cx1);
         row0_ff <= RowW'(ry0);
         row1_ff <= RowW'(ry1);
      end
      if (rdv_ff) begin
         corner_ff[0][rds_ff] <= rd1_ff;
         corner_ff[1][rds_ff] <= rd2_ff;
      end
      if (cmd.mul_en) begin
         prod_ff <= 64'(prod);
         z0_ff   <= z0;
      end
      if (cmd.lerp_store) begin
         unique case (cmd.lerp_op)
            LERP_AB_X: e_ff[cmd.motor] <= 32'(lerp_sum);
            LERP_CD_X: f_ff[cmd.motor] <= 32'(lerp_sum);
            default:   g_ff[cmd.motor] <= 32'(lerp_sum);
         endcase
      end
      if (cmd.out_load) begin
         ierr_ff <= err_ff;
         ok_ff   <= !err_ff && ok;
         m1_ff   <= (!err_ff && ok) ? sel1 : '0;
         m2_ff   <= (!err_ff && ok) ? sel2 : '0;
      end
   end

   assign st.div_done   = div_done;
   assign st.index_err  = err_ff;
   assign st.corners_ok = ok;
   assign st.grid_x     = gx_ff;
   assign st.grid_y     = gy_ff;
   assign st.rsp_full   = rsp_valid_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_motor_one_angle = m1_ff;
   assign rsp_motor_two_angle = m2_ff;
   assign rsp_result_valid    = ok_ff;
   assign rsp_index_error     = ierr_ff;

   a_err_not_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ierr_ff |-> !ok_ff)
      else $error("index error reported with a valid result");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> (m1_ff == '0) && (m2_ff == '0))
      else $error("invalid result carries nonzero angles");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("result loaded over a pending one");
endmodule
`default_nettype wire

>>> design/gtbi_ctrl.sv
// controller: sequences grid split, index check, reads and interpolations
`default_nettype none
module gtbi_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_func,
   output logic                      req_stall,
   input  wire gtbi_pkg::status_type st,
   output gtbi_pkg::cmd_type         cmd
);
   import gtbi_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIVX  = 4'd1;
   localparam logic [3:0] S_WX    = 4'd2;
   localparam logic [3:0] S_DIVY  = 4'd3;
   localparam logic [3:0] S_WY    = 4'd4;
   localparam logic [3:0] S_GRID  = 4'd5;
   localparam logic [3:0] S_IDX   = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_LSEL  = 4'd8;
   localparam logic [3:0] S_MUL   = 4'd9;
   localparam logic [3:0] S_LDIV  = 4'd10;
   localparam logic [3:0] S_LWAIT = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       motor_ff, motor_in;
   logic [1:0] n_ops;
   logic [1:0] op;

   always_comb begin
      if (st.grid_x && st.grid_y) begin
         n_ops = 2'd0;
         op    = LERP_AB_X;
      end else if (st.grid_x) begin
         n_ops = 2'd1;
         op    = LERP_AC_Y;
      end else if (st.grid_y) begin
         n_ops = 2'd1;
         op    = LERP_AB_X;
      end else begin
         n_ops = 2'd3;
         unique case (idx_ff)
            2'd0:    op = LERP_AB_X;
            2'd1:    op = LERP_CD_X;
            default: op = LERP_EF_Y;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      motor_in  = motor_ff;
      cmd       = '0;
      cmd.lerp_op = op;
      cmd.motor   = motor_ff;
      cmd.rd_sel  = cnt_ff[1:0];
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_func) begin
               cmd.write_en = 1'b1;
            end else if (req_valid) begin
               cmd.query_load = 1'b1;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TIP;
            state_in      = S_WX;
         end
         S_WX: begin
            if (st.div_done) begin
               cmd.store_x = 1'b1;
               state_in    = S_DIVY;
            end
         end
         S_DIVY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TILT;
            state_in      = S_WY;
         end
         S_WY: begin
            if (st.div_done) begin
               cmd.store_y = 1'b1;
               state_in    = S_GRID;
            end
         end
         S_GRID: begin
            cmd.grid_eval = 1'b1;
            state_in      = S_IDX;
         end
         S_IDX: begin
            cmd.idx_eval = 1'b1;
            cnt_in       = '0;
            state_in     = S_RD;
         end
         S_RD: begin
            // four reads, none on an index error, then wait for the read and corner capture registers
            if (st.index_err) begin
               state_in = S_LSEL;
            end else begin
               cmd.rd_en = !cnt_ff[2];
               cnt_in    = cnt_ff + 1'b1;
               if (cnt_ff == 3'd5) begin
                  state_in = S_LSEL;
               end
            end
            idx_in   = '0;
            motor_in = 1'b0;
         end
         S_LSEL: begin
            if (st.index_err || !st.corners_ok || n_ops == 2'd0) begin
               state_in = S_FIN;
            end else if (idx_ff == n_ops) begin
               if (motor_ff) begin
                  state_in = S_FIN;
               end else begin
                  motor_in = 1'b1;
                  idx_in   = '0;
               end
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_LDIV;
         end
         S_LDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LERP;
            state_in      = S_LWAIT;
         end
         S_LWAIT: begin
            if (st.div_done) begin
               cmd.lerp_store = 1'b1;
               idx_in         = idx_ff + 1'b1;
               state_in       = S_LSEL;
            end
         end
         S_FIN: begin
            if (!st.rsp_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      motor_ff <= motor_in;
   end

   a_rd_no_err: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !st.index_err)
      else $error("table read with an off-table index");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |-> state_ff == S_IDLE && !req_stall)
      else $error("table write outside idle");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !st.div_done)
      else $error("divider done right after start");
endmodule
`default_nettype wire

>>> design/gimbal_table_bilinear_interp.sv
// top level: gimbal tip/tilt to motor angles by table interpolation
//
//  port group | dir | handshake          | moves
//  req_*      | in  | req_valid/req_stall | table write or angle query
//  rsp_*      | out | rsp_valid/rsp_stall | motor angles and flags of a query
//  csr_*      | in  | csr_valid/csr_ready | grid step
//
// a table write is taken at once in idle; a query transfer stalls the input until
// its result is loaded, through the grid split, the corner reads and 0, 2 or 6
// interpolations; the one-bit-per-cycle divider is shared by split and interpolations.
// reset is synchronous; tables are not cleared and must be written before use.
// a finished result waits in the output register while writes keep flowing.
`default_nettype none
module gimbal_table_bilinear_interp #(
   parameter int unsigned TIP_COLS    = gtbi_pkg::TipColsDefault,
   parameter int unsigned TILT_ROWS   = gtbi_pkg::TiltRowsDefault,
   parameter int unsigned TIP_OFFSET  = gtbi_pkg::TipOffsetDefault,
   parameter int unsigned TILT_OFFSET = gtbi_pkg::TiltOffsetDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic               req_table_select,
   input  wire logic [6:0]         req_row_index,
   input  wire logic [6:0]         req_col_index,
   input  wire logic signed [31:0] req_entry_value,
   input  wire logic signed [31:0] req_tip_angle,
   input  wire logic signed [31:0] req_tilt_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_motor_one_angle,
   output logic signed [31:0]      rsp_motor_two_angle,
   output logic                    rsp_result_valid,
   output logic                    rsp_index_error,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [30:0]        csr_step_angle
);
   import gtbi_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   gtbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   gtbi_dp #(
      .TIP_COLS    (TIP_COLS),
      .TILT_ROWS   (TILT_ROWS),
      .TIP_OFFSET  (TIP_OFFSET),
      .TILT_OFFSET (TILT_OFFSET)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .csr_valid           (csr_valid),
      .csr_step_angle      (csr_step_angle),
      .req_table_select    (req_table_select),
      .req_row_index       (req_row_index),
      .req_col_index       (req_col_index),
      .req_entry_value     (req_entry_value),
      .req_tip_angle       (req_tip_angle),
      .req_tilt_angle      (req_tilt_angle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_motor_one_angle (rsp_motor_one_angle),
      .rsp_motor_two_angle (rsp_motor_two_angle),
      .rsp_result_valid    (rsp_result_valid),
      .rsp_index_error     (rsp_index_error)
   );
endmodule
`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the gimbal table interpolator
`default_nettype none
module testbench;
   localparam int unsigned Cols      = 128;
   localparam int unsigned Rows      = 128;
   localparam int          TipOff    = 38;
   localparam int          TiltOff   = 55;
   localparam longint      StepReset = 4685049;
   localparam bit          FuncWrite = 1'b0;
   localparam bit          FuncQuery = 1'b1;
   localparam int          FracExact = 0;
   localparam int          FracLow   = 1;
   localparam int          FracHigh  = 2;
   localparam int          FracAny   = 3;

   typedef struct {
      int m1;
      int m2;
      bit ok;
      bit err;
   } motor_result_type;

   class interp_scoreboard;
      int               motor1 [Rows*Cols];
      int               motor2 [Rows*Cols];
      longint           step_angle = StepReset;
      motor_result_type pending_angles [$];
      int               errors  = 0;
      int               checked = 0;

      static function void split(longint a, longint s, output longint q, output longint r);
         q = a / s;
         r = a % s;
         if (r < 0) begin
            r += s;
            q -= 1;
         end
      endfunction

      static function bit near_grid(longint r, longint s);
         return (r * 1000 < s) || ((s - r) * 1000 < s);
      endfunction

      static function longint lerp(longint z0, longint z1, longint r, longint s);
         longint q, m;
         split((z1 - z0) * r, s, q, m);
         if (2 * m >= s) q += 1;
         return z0 + q;
      endfunction

      // grid cells a query touches; returns 1 when all lie inside the tables
      function bit span(int tip, int tilt, output int c0, output int c1,
                        output int r0, output int r1);
         longint s, qx, rx, qy, ry;
         s = (step_angle == 0) ? 1 : step_angle;
         split(longint'(tip), s, qx, rx);
         split(longint'(tilt), s, qy, ry);
         if (near_grid(rx, s)) begin
            c0 = int'((rx * 1000 < s ? qx : qx + 1) + TipOff);
            c1 = c0;
         end else begin
            c0 = int'(qx + TipOff);
            c1 = c0 + 1;
         end
         if (near_grid(ry, s)) begin
            r0 = int'((ry * 1000 < s ? qy : qy + 1) + TiltOff);
            r1 = r0;
         end else begin
            r0 = int'(qy + TiltOff);
            r1 = r0 + 1;
         end
         return !(c0 < 0 || c1 >= Cols || r0 < 0 || r1 >= Rows);
      endfunction

      function motor_result_type predict_motor_angles(int tip, int tilt);
         motor_result_type res;
         longint s, qx, rx, qy, ry;
         longint a1, b1, c1v, d1, a2, b2, c2, d2;
         int c0, c1, r0, r1;
         bit gx, gy;
         res = '{0, 0, 1'b0, 1'b0};
         s = (step_angle == 0) ? 1 : step_angle;
         split(longint'(tip), s, qx, rx);
         split(longint'(tilt), s, qy, ry);
         gx = near_grid(rx, s);
         gy = near_grid(ry, s);
         if (!span(tip, tilt, c0, c1, r0, r1)) begin
            res.err = 1'b1;
            return res;
         end
         a1 = motor1[r0*Cols+c0];  b1 = motor1[r0*Cols+c1];
         c1v = motor1[r1*Cols+c0]; d1 = motor1[r1*Cols+c1];
         a2 = motor2[r0*Cols+c0];  b2 = motor2[r0*Cols+c1];
         c2 = motor2[r1*Cols+c0];  d2 = motor2[r1*Cols+c1];
         if (gx && gy) begin
            res = '{int'(a1), int'(a2), 1'b1, 1'b0};
         end else if (gx) begin
            if (a1 >= 0 && c1v >= 0)
               res = '{int'(lerp(a1, c1v, ry, s)), int'(lerp(a2, c2, ry, s)), 1'b1, 1'b0};
         end else if (gy) begin
            if (a1 >= 0 && b1 >= 0)
               res = '{int'(lerp(a1, b1, rx, s)), int'(lerp(a2, b2, rx, s)), 1'b1, 1'b0};
         end else if (a1 >= 0 && b1 >= 0 && c1v >= 0 && d1 >= 0) begin
            res.m1 = int'(lerp(lerp(a1, b1, rx, s), lerp(c1v, d1, rx, s), ry, s));
            res.m2 = int'(lerp(lerp(a2, b2, rx, s), lerp(c2, d2, rx, s), ry, s));
            res.ok = 1'b1;
         end
         return res;
      endfunction

      function void note_request(bit func, bit sel, bit [6:0] row, bit [6:0] col,
                                 int value, int tip, int tilt);
         if (func == FuncWrite) begin
            if (sel) motor2[row*Cols+col] = value;
            else     motor1[row*Cols+col] = value;
         end else begin
            pending_angles.push_back(predict_motor_angles(tip, tilt));
         end
      endfunction

      function void check_response(int m1, int m2, bit ok, bit err);
         motor_result_type want;
         if (pending_angles.size() == 0) begin
            $display("%0t: unexpected result m1=%0d m2=%0d", $time, m1, m2);
            errors++;
            return;
         end
         want = pending_angles.pop_front();
         checked++;
         if (m1 !== want.m1) begin
            $display("%0t: motor_one_angle exp %0d act %0d", $time, want.m1, m1);
            errors++;
         end
         if (m2 !== want.m2) begin
            $display("%0t: motor_two_angle exp %0d act %0d", $time, want.m2, m2);
            errors++;
         end
         if (ok !== want.ok) begin
            $display("%0t: result_valid exp %0b act %0b", $time, want.ok, ok);
            errors++;
         end
         if (err !== want.err) begin
            $display("%0t: index_error exp %0b act %0b", $time, want.err, err);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic              req_table_select = 1'b0;
   logic [6:0]        req_row_index = '0;
   logic [6:0]        req_col_index = '0;
   logic signed [31:0] req_entry_value = '0;
   logic signed [31:0] req_tip_angle = '0;
   logic signed [31:0] req_tilt_angle = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_motor_one_angle;
   logic signed [31:0] rsp_motor_two_angle;
   logic              rsp_result_valid;
   logic              rsp_index_error;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [30:0]       csr_step_angle = '0;

   interp_scoreboard sb = new();
   bit  filled [2][Rows*Cols];
   int  burst_left = 1;
   int  items = 0;
   int  queries = 0;
   int  steps_used = 1;
   int  hold_req = 0;
   int  hold_seen = 0;
   int  hold_cnt = 0;
   int  stall_mode = 0;
   int  mode_cnt = 0;

   gimbal_table_bilinear_interp dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_func, .req_table_select, .req_row_index,
      .req_col_index, .req_entry_value, .req_tip_angle, .req_tilt_angle,
      .rsp_valid, .rsp_stall, .rsp_motor_one_angle, .rsp_motor_two_angle,
      .rsp_result_valid, .rsp_index_error,
      .csr_valid, .csr_ready, .csr_step_angle
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 8_000_000);
      $display("timeout with %0d results outstanding", sb.pending_angles.size());
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_func, req_table_select, req_row_index, req_col_index,
                            req_entry_value, req_tip_angle, req_tilt_angle);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_motor_one_angle, rsp_motor_two_angle,
                              rsp_result_valid, rsp_index_error);
      end
   end

   // receiver back-pressure: long hold on request, else a changing pattern
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_cnt  = 3000;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_cnt   = $urandom_range(50, 600);
         end
         mode_cnt--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (mode_cnt % 40) < 25;
         endcase
      end
   end

   task automatic send_item(bit func, bit sel, bit [6:0] row, bit [6:0] col,
                            int value, int tip, int tilt);
      req_valid        <= 1'b1;
      req_func         <= func;
      req_table_select <= sel;
      req_row_index    <= row;
      req_col_index    <= col;
      req_entry_value  <= value;
      req_tip_angle    <= tip;
      req_tilt_angle   <= tilt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic send_write(bit sel, int row, int col, int value);
      filled[sel][row*Cols+col] = 1'b1;
      send_item(FuncWrite, sel, row[6:0], col[6:0], value, $urandom, $urandom);
   endtask

   task automatic send_query(int tip, int tilt);
      int c0, c1, r0, r1, v;
      if (sb.span(tip, tilt, c0, c1, r0, r1)) begin
         // every corner of both tables must hold a written value first
         for (int t = 0; t < 2; t++)
            for (int i = 0; i < 2; i++)
               for (int j = 0; j < 2; j++) begin
                  int rr, cc;
                  rr = (i == 0) ? r0 : r1;
                  cc = (j == 0) ? c0 : c1;
                  if (!filled[t][rr*Cols+cc]) begin
                     v = $urandom;
                     if ($urandom_range(0, 99) >= 15) v = v & 32'h7fff_ffff;
                     send_write(t[0], rr, cc, v);
                  end
               end
      end
      queries++;
      send_item(FuncQuery, 1'($urandom), 7'($urandom), 7'($urandom), $urandom, tip, tilt);
   endtask

   function automatic int angle_at(int idx, int off, int frac);
      longint s, a, lim;
      s   = sb.step_angle;
      lim = (s - 1) / 1000;
      if ((frac == FracLow || frac == FracHigh) && lim < 1) frac = FracExact;
      a = longint'(idx - off) * s;
      case (frac)
         FracLow:  a += $urandom_range(0, int'(lim));
         FracHigh: a -= $urandom_range(1, int'(lim));
         FracAny:  a += $urandom_range(0, int'(s - 1));
         default:  ;
      endcase
      if (a < -64'sd2147483648 || a > 64'sd2147483647) return $urandom;
      return int'(a);
   endfunction

   task automatic query_at(int col, int row, int fx, int fy);
      send_query(angle_at(col, TipOff, fx), angle_at(row, TiltOff, fy));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         send_write(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom);
      else if (pick < 14)
         send_query($urandom, $urandom);
      else
         query_at(int'($urandom_range(0, 137)) - 5, int'($urandom_range(0, 137)) - 5,
                  $urandom_range(0, 3), $urandom_range(0, 3));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_angles.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_step(longint s);
      drain();
      csr_valid      <= 1'b1;
      csr_step_angle <= s[30:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.step_angle = s;
      steps_used++;
   endtask

   initial begin
      longint step_plan [$];
      step_plan = '{1, 2147483647, 0, 3, 12345678, 4685049};
      step_plan[2] = $urandom_range(2000, 40_000_000);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the write fields, both tables
      send_write(0, 0, 0, 32'sh8000_0000);
      send_write(1, 127, 127, 32'sh7fff_ffff);
      send_write(1, 0, 127, 0);
      send_write(0, 127, 0, 32'sh7fff_ffff);
      query_at(0, 0, FracExact, FracExact);
      query_at(127, 127, FracExact, FracExact);
      query_at(40, 60, FracAny, FracExact);
      query_at(40, 60, FracExact, FracAny);
      query_at(40, 60, FracAny, FracAny);
      query_at(41, 61, FracLow, FracHigh);
      // negative motor-one corner invalidates interpolation
      send_write(0, 70, 50, -5);
      query_at(50, 70, FracAny, FracAny);
      query_at(50, 70, FracExact, FracAny);
      query_at(50, 70, FracAny, FracExact);
      // off the table on the column sides and past the last row
      query_at(127, 60, FracAny, FracExact);
      query_at(-1, 60, FracExact, FracExact);
      query_at(60, 128, FracExact, FracExact);
      send_query(32'sh8000_0000, 32'sh7fff_ffff);

      while (items < 170) random_item();
      foreach (step_plan[p]) begin
         set_step(step_plan[p]);
         if (p == 2) begin
            // stall the result side for a long time while queries keep coming
            hold_req++;
            repeat (6) query_at($urandom_range(10, 100), $urandom_range(10, 100),
                                FracAny, FracAny);
            drain();
         end
         while (items < 170 + (p + 1) * 80) random_item();
      end

      drain();
      $display("covered %0d transfers: %0d queries, %0d results checked", items, queries,
               sb.checked);
      $display("grid steps used: %0d, including the smallest and largest", steps_used);
      if (sb.errors == 0 && sb.pending_angles.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
design/gtbi_pkg.sv
design/gtbi_div.sv
design/gtbi_dp.sv
design/gtbi_ctrl.sv
design/gimbal_table_bilinear_interp.sv
verif/testbench.sv
